@@ hw/rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the periodic poll scheduler with backoff.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int SLOTS_DEF   = 4;
   localparam int SLOT_LIMIT  = 4;      // slots that have a period register
   localparam int TIME_W      = 32;
   localparam int STREAK_W    = 8;
   localparam int PERIOD_W    = 16;
   localparam int UNIT_W      = 13;
   localparam int CAP_W       = 4;
   localparam int DELAY_W     = UNIT_W + CAP_W;
   localparam int WAKE_W      = 16;
   localparam int COUNT_W     = 3;
   localparam int MASK_W      = 4;
   localparam int SLOT_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 32;

   localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd200;
   localparam logic [STREAK_W-1:0] STREAK_CAP = 8'd10;

   localparam logic [COUNT_W-1:0]  SLOT_COUNT_RST = 3'd1;
   localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd1000;
   localparam logic [UNIT_W-1:0]   BACKOFF_RST    = 13'd50;
   localparam logic [WAKE_W-1:0]   FALLBACK_RST   = 16'd1000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SLOT_COUNT = 3'd0,
      REG_PERIOD0    = 3'd1,
      REG_PERIOD1    = 3'd2,
      REG_PERIOD2    = 3'd3,
      REG_PERIOD3    = 3'd4,
      REG_BACKOFF    = 3'd5,
      REG_FALLBACK   = 3'd6
   } csr_reg_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_SCAN  = 1'b1
   } op_type;

   typedef enum logic {
      KIND_POLL = 1'b0,
      KIND_WAKE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WAKE = 3'b100
   } state_type;

   // Result of the update unit at the head of the ring
   typedef struct packed {
      logic [TIME_W-1:0]   due;
      logic [STREAK_W-1:0] streak;
      logic                polled;
      logic                ok;
      logic [WAKE_W-1:0]   best;
   } head_res_type;

endpackage

@@ hw/rtl/pps_cell.sv @@
// ----------------------------------------------------------------------------
// pps_cell
// One slot of the state ring: due time and error streak, shifted on
// toward the head each scan step, loaded in parallel on a start.
// ----------------------------------------------------------------------------
module pps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_en,
   input  logic [pps_pkg::TIME_W-1:0]    load_due,
   input  logic                          shift_en,
   input  logic [pps_pkg::TIME_W-1:0]    chain_due,
   input  logic [pps_pkg::STREAK_W-1:0]  chain_streak,
   output logic [pps_pkg::TIME_W-1:0]    due,
   output logic [pps_pkg::STREAK_W-1:0]  streak
);
   import pps_pkg::*;

   logic [TIME_W-1:0]   due_ff, due_in;
   logic [STREAK_W-1:0] streak_ff, streak_in;

   always_comb begin
      due_in    = due_ff;
      streak_in = streak_ff;
      if (load_en) begin
         due_in    = load_due;
         streak_in = '0;
      end else if (shift_en) begin
         due_in    = chain_due;
         streak_in = chain_streak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_ff    <= '0;
         streak_ff <= '0;
      end else begin
         due_ff    <= due_in;
         streak_ff <= streak_in;
      end
   end

   assign due    = due_ff;
   assign streak = streak_ff;

endmodule

@@ hw/rtl/pps_head.sv @@
// ----------------------------------------------------------------------------
// pps_head
// Update unit at the head of the ring: due test, outcome, reschedule and
// running minimum of the wake distance.
// ----------------------------------------------------------------------------
module pps_head (
   input  logic [pps_pkg::TIME_W-1:0]   due_in,
   input  logic [pps_pkg::STREAK_W-1:0] streak_in,
   input  logic [pps_pkg::TIME_W-1:0]   now,
   input  logic                         active,
   input  logic                         ok,
   input  logic [pps_pkg::PERIOD_W-1:0] period,
   input  logic [pps_pkg::UNIT_W-1:0]   backoff,
   input  logic [pps_pkg::WAKE_W-1:0]   best_in,
   output pps_pkg::head_res_type        res
);
   import pps_pkg::*;

   logic [TIME_W-1:0]   diff_pre, diff_post;
   logic                is_due;
   logic [STREAK_W-1:0] streak_inc;
   logic [CAP_W-1:0]    cap;
   logic [DELAY_W-1:0]  delay;

   // wrap-aware: due when due - now is zero or negative
   assign diff_pre = due_in - now;
   assign is_due   = active && ((diff_pre == '0) || diff_pre[TIME_W-1]);

   always_comb begin
      streak_inc = (streak_in < STREAK_MAX) ? streak_in + 8'd1 : streak_in;
      cap        = (streak_inc > STREAK_CAP) ? CAP_W'(STREAK_CAP) : streak_inc[CAP_W-1:0];
      delay      = ok ? DELAY_W'(period) : DELAY_W'(DELAY_W'(backoff) * DELAY_W'(cap));

      res.polled = is_due;
      res.ok     = ok;
      if (is_due) begin
         res.due    = now + TIME_W'(delay);
         res.streak = ok ? '0 : streak_inc;
         diff_post  = TIME_W'(delay);
      end else begin
         res.due    = due_in;
         res.streak = streak_in;
         diff_post  = diff_pre;
      end

      res.best = best_in;
      if (active && (diff_post != '0) && !diff_post[TIME_W-1] &&
          (diff_post < TIME_W'(best_in))) begin
         res.best = diff_post[WAKE_W-1:0];
      end
   end

endmodule

@@ hw/rtl/periodic_poll_scheduler_with_backoff_top.sv @@
// ----------------------------------------------------------------------------
// periodic_poll_scheduler_with_backoff_top
// Poll scheduler: per-slot due times and error streaks in a ring of cells,
// one update unit at the head, poll reports and a wake delay per scan.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | contents
//   req_    | in  | tvalid/tready      | tuser operation, tdata now, read_ok_mask
//   rsp_    | out | tvalid/tready      | tuser kind, tdata report fields, tlast
//   csr_    | in  | we (no handshake)  | addr register index, wdata value
//
// A start transaction loads the due times in parallel. After a scan is accepted, the
// ring rotates once per cycle, while the result side is free, through the single
// head update unit; then the wake delay is issued into the result register and the
// next request can be accepted.
// Reset is synchronous; it clears due times, streaks and the registers to
// their defaults. A stalled result holds the ring until the output register
// frees up. The next request is taken while the last result still waits.
// ----------------------------------------------------------------------------
module periodic_poll_scheduler_with_backoff_top #(
   parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] now, [35:32] read_ok_mask, [39:36] zero
   input  logic [pps_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] slot, [2] read_ok, [10:3] streak, [26:11] wake_delay, [31:27] zero
   output logic [pps_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pps_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int LIM   = (SLOTS < SLOT_LIMIT) ? SLOTS : SLOT_LIMIT;

   // configuration
   logic [COUNT_W-1:0]  slot_count_ff, slot_count_in;
   logic [PERIOD_W-1:0] period_ff [SLOT_LIMIT];
   logic [PERIOD_W-1:0] period_in [SLOT_LIMIT];
   logic [UNIT_W-1:0]   backoff_ff, backoff_in;
   logic [WAKE_W-1:0]   fallback_ff, fallback_in;

   // sequencer
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic [WAKE_W-1:0]   best_ff, best_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [STREAK_W-1:0] rsp_streak_ff, rsp_streak_in;
   logic [WAKE_W-1:0]   rsp_wake_ff, rsp_wake_in;

   logic                req_accept, out_free, shift_en, start_load;
   logic [COUNT_W-1:0]  n_active;
   logic [4:0]          step_wide;
   logic [SLOT_W-1:0]   step_slot;
   logic                head_active;
   head_res_type        head_res;

   logic [TIME_W-1:0]   cell_due    [SLOTS];
   logic [STREAK_W-1:0] cell_streak [SLOTS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign shift_en   = (state_ff == ST_SCAN) && out_free;
   assign start_load = req_accept && (op_type'(req_tuser) == OP_START);

   assign n_active    = (slot_count_ff > COUNT_W'(LIM)) ? COUNT_W'(LIM) : slot_count_ff;
   assign step_wide   = 5'(step_ff);
   assign step_slot   = step_wide[SLOT_W-1:0];
   assign head_active = step_wide < 5'(n_active);

   // ---- configuration registers ----
   always_comb begin
      slot_count_in = slot_count_ff;
      period_in     = period_ff;
      backoff_in    = backoff_ff;
      fallback_in   = fallback_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_addr))
            REG_SLOT_COUNT: slot_count_in = csr_wdata[COUNT_W-1:0];
            REG_PERIOD0:    period_in[0]  = csr_wdata;
            REG_PERIOD1:    period_in[1]  = csr_wdata;
            REG_PERIOD2:    period_in[2]  = csr_wdata;
            REG_PERIOD3:    period_in[3]  = csr_wdata;
            REG_BACKOFF:    backoff_in    = csr_wdata[UNIT_W-1:0];
            REG_FALLBACK:   fallback_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RST;
         for (int i = 0; i < SLOT_LIMIT; i++) period_ff[i] <= PERIOD_RST;
         backoff_ff    <= BACKOFF_RST;
         fallback_ff   <= FALLBACK_RST;
      end else begin
         slot_count_ff <= slot_count_in;
         period_ff     <= period_in;
         backoff_ff    <= backoff_in;
         fallback_ff   <= fallback_in;
      end
   end

   // ---- ring of slot cells, head is cell 0 ----
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      logic [TIME_W-1:0]   nxt_due;
      logic [STREAK_W-1:0] nxt_streak;
      if (k == SLOTS - 1) begin : g_tail
         assign nxt_due    = head_res.due;
         assign nxt_streak = head_res.streak;
      end else begin : g_mid
         assign nxt_due    = cell_due[k+1];
         assign nxt_streak = cell_streak[k+1];
      end
      pps_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .load_en      (start_load),
         .load_due     (req_tdata[TIME_W-1:0]),
         .shift_en     (shift_en),
         .chain_due    (nxt_due),
         .chain_streak (nxt_streak),
         .due          (cell_due[k]),
         .streak       (cell_streak[k])
      );
   end

   pps_head u_head (
      .due_in    (cell_due[0]),
      .streak_in (cell_streak[0]),
      .now       (now_ff),
      .active    (head_active),
      .ok        (mask_ff[step_slot]),
      .period    (period_ff[step_slot]),
      .backoff   (backoff_ff),
      .best_in   (best_ff),
      .res       (head_res)
   );

   // ---- sequencer and result register ----
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      now_in        = now_ff;
      mask_in       = mask_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_streak_in = rsp_streak_ff;
      rsp_wake_in   = rsp_wake_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (op_type'(req_tuser) == OP_SCAN)) begin
               now_in   = req_tdata[TIME_W-1:0];
               mask_in  = req_tdata[TIME_W +: MASK_W];
               best_in  = fallback_ff;
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (shift_en) begin
               best_in = head_res.best;
               step_in = step_ff + CNT_W'(1);
               if (head_res.polled) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_POLL;
                  rsp_slot_in   = step_slot;
                  rsp_ok_in     = head_res.ok;
                  rsp_streak_in = head_res.streak;
                  rsp_wake_in   = '0;
               end
               if (step_ff == CNT_W'(SLOTS - 1)) state_in = ST_WAKE;
            end
         end
         ST_WAKE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_WAKE;
               rsp_slot_in   = '0;
               rsp_ok_in     = 1'b0;
               rsp_streak_in = '0;
               rsp_wake_in   = (best_ff == '0) ? WAKE_W'(1) : best_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      mask_ff       <= mask_in;
      best_ff       <= best_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_streak_ff <= rsp_streak_in;
      rsp_wake_ff   <= rsp_wake_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = (rsp_kind_ff == KIND_WAKE);
   assign rsp_tdata  = {5'b0, rsp_wake_ff, rsp_streak_ff, rsp_ok_ff, rsp_slot_ff};

endmodule

@@ hw/rtl/pps_checker.sv @@
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the poll scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import pps_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // only the wake delay closes a scan
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("tlast does not match wake kind");

   // wake delay is never zero
   a_wake_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[26:11] != '0))
      else $error("zero wake delay");

   // poll report: no wake field, streak saturated at its limit
   a_poll_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[26:11] == '0) && (rsp_tdata[10:3] <= STREAK_MAX))
      else $error("bad poll report fields");

   // a successful read clears the streak
   a_ok_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[2] |-> (rsp_tdata[10:3] == '0))
      else $error("streak not cleared on success");

endmodule

bind periodic_poll_scheduler_with_backoff_top pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
